// ----- design/rsm_pkg.sv -----
package rsm_pkg;

    localparam int SCORE_W      = 16;
    localparam int MEDIAN_W     = 17;
    localparam int COUNT_W      = 7;
    localparam int MAX_SCORES_D = 64;

    typedef logic [SCORE_W-1:0] t_score;

    typedef struct packed {
        logic ins;
        logic occ;
        logic prev_gt;
    } t_cell_ctl;

endpackage

// ----- design/rsm_cell.sv -----
module rsm_cell
    import rsm_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_score    i_score,
    input  t_score    i_prev_val,
    output t_score    o_val,
    output logic      o_gt
);

    t_score r_val;
    t_score n_val;

    // occupied and larger than the new score: this entry moves up one slot
    assign o_gt  = i_ctl.occ && (r_val > i_score);
    assign o_val = r_val;

    always_comb begin
        if (i_ctl.prev_gt) begin
            n_val = i_prev_val;
        end else if (o_gt || !i_ctl.occ) begin
            n_val = i_score;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_val <= n_val;
        end
    end

endmodule

// ----- design/running_set_median.sv -----
// running_set_median
// Command port: a score beat is taken at a rising edge with start high and busy
// low. i_score is the score, i_last marks the final score of a set.
// Scores enter a row of MAX_SCORES compare-and-shift cells, one score per cycle
// while busy is low; every cell decides in parallel whether to keep, take the new
// score or take its lower neighbor's value, so the row stays sorted ascending.
// Scores arriving with the row full are dropped and reported via o_overflow.
// Result: a taken last beat sets r_fin, which loads r_valid and the result registers;
// the result is shown on o_median_twice, o_count and o_overflow with o_valid high
// for one cycle.
// Throughput: one score per cycle within a set; after a last beat busy is high
// for one cycle while the two middle cells are selected and summed.
// o_median_twice is the sum of the two middle entries (even count) or twice the
// middle entry (odd count). o_count is the number of kept scores modulo 128.
// The receiver cannot stall; each result must be captured in its strobe cycle.
// Reset (i_rst_n low, synchronous) empties the set and clears busy and o_valid.
module running_set_median
    import rsm_pkg::*;
#(
    parameter int MAX_SCORES = MAX_SCORES_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SCORE_W-1:0]  i_score,
    input  logic                i_last,
    output logic                o_valid,
    output logic [MEDIAN_W-1:0] o_median_twice,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_overflow
);

    localparam int CW = $clog2(MAX_SCORES + 1);
    localparam int IW = $clog2(MAX_SCORES);

    logic                accept;
    logic                room;
    logic                r_fin;
    logic [CW-1:0]       r_count;
    logic                r_drop;
    logic                r_valid;
    logic [MEDIAN_W-1:0] r_median;
    logic [COUNT_W-1:0]  r_ocount;
    logic                r_oflow;
    logic [IW-1:0]       mid_hi;
    logic [IW-1:0]       mid_lo;
    logic [COUNT_W-1:0]  count_ext;

    t_score              cell_val [MAX_SCORES];
    logic                cell_gt  [MAX_SCORES];
    t_score              sel_lo;
    t_score              sel_hi;

    assign accept = start && !busy;
    assign room   = (r_count < CW'(MAX_SCORES));
    assign busy   = r_fin;

    genvar g;
    generate
        for (g = 0; g < MAX_SCORES; g++) begin : g_cell
            t_cell_ctl ctl;
            assign ctl.ins     = accept && room;
            assign ctl.occ     = (CW'(g) < r_count);
            if (g == 0) begin : g_first
                assign ctl.prev_gt = 1'b0;
                rsm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (ctl),
                    .i_score    (i_score),
                    .i_prev_val (i_score),
                    .o_val      (cell_val[g]),
                    .o_gt       (cell_gt[g])
                );
            end else begin : g_rest
                assign ctl.prev_gt = cell_gt[g-1];
                rsm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (ctl),
                    .i_score    (i_score),
                    .i_prev_val (cell_val[g-1]),
                    .o_val      (cell_val[g]),
                    .o_gt       (cell_gt[g])
                );
            end
        end
    endgenerate

    // count is at least 1 whenever r_fin is set
    assign mid_hi = IW'(r_count >> 1);
    assign mid_lo = r_count[0] ? mid_hi : (mid_hi - IW'(1));

    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        for (int i = 0; i < MAX_SCORES; i++) begin
            sel_lo = sel_lo | (cell_val[i] & {SCORE_W{mid_lo == IW'(i)}});
            sel_hi = sel_hi | (cell_val[i] & {SCORE_W{mid_hi == IW'(i)}});
        end
    end

    generate
        if (CW >= COUNT_W) begin : g_cnt_trunc
            assign count_ext = r_count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign count_ext = {{(COUNT_W-CW){1'b0}}, r_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin   <= 1'b0;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_fin;
            if (r_fin) begin
                r_fin   <= 1'b0;
                r_count <= '0;
                r_drop  <= 1'b0;
            end else if (accept) begin
                r_fin <= i_last;
                if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin) begin
            r_median <= {1'b0, sel_lo} + {1'b0, sel_hi};
            r_ocount <= count_ext;
            r_oflow  <= r_drop;
        end
    end

    assign o_valid        = r_valid;
    assign o_median_twice = r_median;
    assign o_count        = r_ocount;
    assign o_overflow     = r_oflow;

`ifndef SYNTHESIS
    a_fin_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> o_valid)
        else $error("finished set produced no result");

    a_no_double_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SCORES))
        else $error("kept count beyond capacity");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> (r_count == '0) && !r_drop)
        else $error("set state not cleared after result");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import rsm_pkg::*;

    typedef struct packed {
        logic [MEDIAN_W-1:0] median_twice;
        logic [COUNT_W-1:0]  count;
        logic                overflow;
    } t_set_result;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_TIES,
        SPREAD_EDGE
    } t_spread;

    localparam int LIMIT_TIME  = 2_000_000;
    localparam int TAIL_CYCLES = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_score              i_score;
    logic                i_last;
    logic                o_valid;
    logic [MEDIAN_W-1:0] o_median_twice;
    logic [COUNT_W-1:0]  o_count;
    logic                o_overflow;

    t_score      kept_scores[$];
    logic        dropped = 1'b0;
    t_set_result pending_medians[$];
    int          n_errors = 0;
    int          beats_sent = 0;
    bit          gaps_on = 1'b0;

    running_set_median dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_score        (i_score),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_median_twice (o_median_twice),
        .o_count        (o_count),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // insert one accepted beat into the sorted model; on last, queue the median
    function automatic void absorb_score(t_score s, logic fin);
        int          pos;
        int          n;
        int          mid;
        t_set_result r;
        if (kept_scores.size() < MAX_SCORES_D) begin
            pos = 0;
            while (pos < kept_scores.size() && kept_scores[pos] <= s) pos++;
            kept_scores.insert(pos, s);
        end else begin
            dropped = 1'b1;
        end
        if (fin) begin
            n   = kept_scores.size();
            mid = n / 2;
            if (n % 2 == 0) begin
                r.median_twice = MEDIAN_W'(int'(kept_scores[mid]) + int'(kept_scores[mid-1]));
            end else begin
                r.median_twice = MEDIAN_W'(2 * int'(kept_scores[mid]));
            end
            r.count    = COUNT_W'(n);
            r.overflow = dropped;
            pending_medians.insert(pending_medians.size(), r);
            kept_scores.delete();
            dropped = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : score_monitor
        t_set_result want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $display("%0t: o_valid unknown, expected 0 or 1, actual %b", $time, o_valid);
                n_errors++;
            end else if (o_valid) begin
                if (pending_medians.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, o_median_twice, o_count, o_overflow);
                    n_errors++;
                end else begin
                    want = pending_medians.pop_front();
                    check_field("median_twice", want.median_twice, o_median_twice);
                    check_field("count", want.count, o_count);
                    check_field("overflow", want.overflow, o_overflow);
                end
            end
            if (start && !busy) absorb_score(i_score, i_last);
        end
    end

    task automatic send_beat(t_score s, logic fin);
        @(negedge i_clk);
        start   <= 1'b1;
        i_score <= s;
        i_last  <= fin;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        if (gaps_on && $urandom_range(99) < 12) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_score <= t_score'($urandom);
            i_last  <= 1'($urandom);
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    task automatic send_fixed(t_score vals[$]);
        foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
    endtask

    function automatic t_score pick_score(t_spread spread);
        case (spread)
            SPREAD_TIES: return t_score'($urandom_range(7));
            SPREAD_EDGE: begin
                if ($urandom_range(1)) return 16'hFFFF - t_score'($urandom_range(1));
                return t_score'($urandom_range(1));
            end
            default:     return t_score'($urandom);
        endcase
    endfunction

    function automatic int pick_set_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(1, 12);
        if (r < 90) return $urandom_range(13, MAX_SCORES_D);
        return $urandom_range(MAX_SCORES_D + 1, MAX_SCORES_D + 8);
    endfunction

    task automatic send_set(int n, t_spread spread);
        for (int i = 0; i < n; i++) send_beat(pick_score(spread), i == n - 1);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        gaps_on = 1'b0;
        send_fixed('{16'h0000});
        send_fixed('{16'hFFFF});
        send_fixed('{16'hFFFF, 16'hFFFF});
        send_fixed('{16'h0000, 16'hFFFF});
        send_fixed('{16'hFFFF, 16'h0000, 16'hFFFF});
        send_fixed('{16'h5555, 16'hAAAA});
        pause_until_drained();
    endtask

    task automatic test_order_and_ties();
        gaps_on = 1'b0;
        send_fixed('{16'd3, 16'd2, 16'd1});
        send_fixed('{16'd1, 16'd2, 16'd3, 16'd4});
        send_fixed('{16'd7, 16'd7, 16'd7, 16'd7});
        send_fixed('{16'd9, 16'd2, 16'd9, 16'd2, 16'd5});
        pause_until_drained();
    endtask

    // exactly full, then one and more past capacity (last beat itself dropped)
    task automatic test_store_full();
        gaps_on = 1'b1;
        send_set(MAX_SCORES_D, SPREAD_FULL);
        send_set(MAX_SCORES_D + 1, SPREAD_EDGE);
        send_set(MAX_SCORES_D + 2, SPREAD_TIES);
        send_set(MAX_SCORES_D + 6, SPREAD_FULL);
        send_set(1, SPREAD_FULL);
        pause_until_drained();
    endtask

    task automatic test_random_sets();
        int sets;
        sets    = 0;
        gaps_on = 1'b1;
        while (beats_sent < 1050) begin
            send_set(pick_set_len(), t_spread'($urandom_range(2)));
            sets++;
            if (sets % 15 == 0) pause_until_drained();
        end
        pause_until_drained();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        while (beats_sent < 1450) send_set(pick_set_len(), t_spread'($urandom_range(2)));
        pause_until_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_score = '0;
        i_last  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_order_and_ties();
        test_store_full();
        test_random_sets();
        test_back_to_back();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("running_set_median test passed");
        end else begin
            $display("running_set_median test failed");
        end
        $finish;
    end

    initial begin
        #LIMIT_TIME;
        $display("timeout");
        $display("running_set_median test failed");
        $finish;
    end

endmodule
